// ----- hdl/rssgsp_pkg.sv -----
// ============================================================================
// rssgsp_pkg: shared types, widths and codes of the safe-gap speed planner
// Field widths, register map, zone codes, the result bundle and the width
// functions that follow from the fixed-point fraction width.
// ============================================================================
package rssgsp_pkg;

    // Default fraction width of every fixed-point quantity.
    localparam int FRAC_BITS_DEF = 8;

    // Field widths.
    localparam int OWN_SPEED_W = 16;
    localparam int REL_SPEED_W = 16;
    localparam int GAP_W       = 20;
    localparam int SAFE_W      = 24;
    localparam int ZONE_W      = 3;

    // Register widths.
    localparam int RHO_W = 10;
    localparam int ACC_W = 12;
    localparam int BRK_W = 12;
    localparam int CAP_W = 16;

    // Derived datapath widths that do not depend on the fraction width.
    localparam int RA_W   = RHO_W + ACC_W;     // rho * a
    localparam int RAR_W  = RA_W + RHO_W;      // rho * a * rho
    localparam int CM_W   = OWN_SPEED_W + 1;   // |v + rel|
    localparam int DEN_W  = BRK_W + 1;         // 2 * braking
    localparam int ZC_W   = SAFE_W + 4;        // 11 * d
    localparam int DIV_STEP = 3;               // quotient bits per divider stage

    // APB register file.
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_REACTION_TIME  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ACCEL      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EGO_MIN_BRAKE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEAD_MAX_BRAKE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_CAP      = 3'd4;

    localparam logic [RHO_W-1:0] RST_REACTION_TIME  = 10'd256;
    localparam logic [ACC_W-1:0] RST_MAX_ACCEL      = 12'd512;
    localparam logic [BRK_W-1:0] RST_EGO_MIN_BRAKE  = 12'd1024;
    localparam logic [BRK_W-1:0] RST_LEAD_MAX_BRAKE = 12'd2048;
    localparam logic [CAP_W-1:0] RST_SPEED_CAP      = 16'd7680;

    // Gap zones.
    localparam logic [ZONE_W-1:0] ZONE_ACCEL = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_HOLD  = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_SOFT  = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_WARN  = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_EMERG = 3'd4;

    typedef struct packed {
        logic [RHO_W-1:0] reaction_time;
        logic [ACC_W-1:0] max_accel;
        logic [BRK_W-1:0] ego_min_brake;
        logic [BRK_W-1:0] lead_max_brake;
        logic [CAP_W-1:0] speed_cap;
    } cfg_t;

    typedef struct packed {
        logic [OWN_SPEED_W-1:0] target_speed;
        logic                   collision_warning;
        logic                   emergency_brake;
        logic [ZONE_W-1:0]      gap_zone;
        logic [SAFE_W-1:0]      safe_gap;
    } res_t;

    function automatic int max_i(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Speed after reaction: v + (rho*a >> F).
    function automatic int vr_w(input int f);
        return max_i(OWN_SPEED_W, RA_W - f) + 1;
    endfunction

    // Reaction distance (rho*v >> F).
    function automatic int t1_w(input int f);
        return RHO_W + OWN_SPEED_W - f;
    endfunction

    // Acceleration distance during reaction (a*rho*rho >> 2F+1).
    function automatic int t2_w(input int f);
        return max_i(1, RAR_W - 2 * f - 1);
    endfunction

    function automatic int t12_w(input int f);
        return max_i(t1_w(f), t2_w(f)) + 1;
    endfunction

    // Dividend and quotient width of both braking divisions.
    function automatic int quo_w(input int f);
        return max_i(2 * vr_w(f), 2 * CM_W);
    endfunction

    // Signed raw safe distance t1 + t2 + t3 - t4.
    function automatic int dr_w(input int f);
        return max_i(t12_w(f), quo_w(f)) + 2;
    endfunction

    // Signed set-speed sum v + delta.
    function automatic int tg_w(input int f);
        return max_i(OWN_SPEED_W, f + 3) + 2;
    endfunction

endpackage

// ----- hdl/rss_gap_speed_planner_core.sv -----
// ============================================================================
// rss_gap_speed_planner_core: longitudinal safe-gap speed planner
// Safe following distance, five-zone gap classification and clamped set
// speed for one request per clock, configured over APB.
// ============================================================================
// The planner takes one request per clock while in_ready is high and returns
// one result per request, in order. Every unit is fully pipelined: three
// product stages, two braking divisions running side by side (ceil(quotient
// width / 3) stages each, 12 at the default 8 fraction bits, one restoring
// step of three quotient bits per stage), four stages for safe distance, zone
// and set speed, and an output register. When the consumer stalls, a second
// result is parked in a skid entry and the whole pipeline holds; in_ready
// drops only while that entry is full, straight from a register. Write
// configuration only while no request is in flight; there is no clearing pass
// after reset.
// ============================================================================
module rss_gap_speed_planner_core
#(
    parameter int FRAC_BITS = rssgsp_pkg::FRAC_BITS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    // APB configuration
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic        [rssgsp_pkg::APB_AW-1:0]       paddr,
    input  logic        [rssgsp_pkg::APB_DW-1:0]       pwdata,
    output logic        [rssgsp_pkg::APB_DW-1:0]       prdata,
    output logic                                       pready,
    // Request channel
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic        [rssgsp_pkg::OWN_SPEED_W-1:0]  own_speed,
    input  logic signed [rssgsp_pkg::REL_SPEED_W-1:0]  lead_rel_speed,
    input  logic        [rssgsp_pkg::GAP_W-1:0]        lead_gap,
    input  logic                                       lead_present,
    // Result channel
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic        [rssgsp_pkg::OWN_SPEED_W-1:0]  target_speed,
    output logic                                       collision_warning,
    output logic                                       emergency_brake,
    output logic        [rssgsp_pkg::ZONE_W-1:0]       gap_zone,
    output logic        [rssgsp_pkg::SAFE_W-1:0]       safe_gap
);
    import rssgsp_pkg::*;

    localparam int T12_W = t12_w(FRAC_BITS);
    localparam int QW    = quo_w(FRAC_BITS);
    localparam int SB_W  = 1 + GAP_W + OWN_SPEED_W;

    cfg_t                   cfg;
    logic                   en;

    logic                   fr_valid;
    logic [QW-1:0]          fr_vr_sq;
    logic [QW-1:0]          fr_cm_sq;
    logic [T12_W-1:0]       fr_t12;
    logic [OWN_SPEED_W-1:0] fr_speed;
    logic [GAP_W-1:0]       fr_gap;
    logic                   fr_present;

    logic [DEN_W-1:0]       ego_den;
    logic [DEN_W-1:0]       lead_den;

    logic                   ego_valid;
    logic [QW-1:0]          ego_quo;
    logic [T12_W-1:0]       ego_t12;
    logic                   lead_valid;
    logic [QW-1:0]          lead_quo;
    logic [SB_W-1:0]        lead_sb;

    res_t                   res;

    rssgsp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The whole pipeline advances together; hold only for a full skid entry.
    assign in_ready = en;

    rssgsp_front #(.FRAC_BITS(FRAC_BITS)) u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .own_speed      (own_speed),
        .lead_rel_speed (lead_rel_speed),
        .lead_gap       (lead_gap),
        .lead_present   (lead_present),
        .cfg            (cfg),
        .out_valid      (fr_valid),
        .vr_sq          (fr_vr_sq),
        .cm_sq          (fr_cm_sq),
        .t12            (fr_t12),
        .speed          (fr_speed),
        .gap            (fr_gap),
        .present        (fr_present)
    );

    // Divisors are twice the braking magnitudes; a zero register counts as one.
    assign ego_den  = {(cfg.ego_min_brake == '0) ? BRK_W'(1) : cfg.ego_min_brake, 1'b0};
    assign lead_den = {(cfg.lead_max_brake == '0) ? BRK_W'(1) : cfg.lead_max_brake, 1'b0};

    // Ego braking distance after reaction; carries the reaction-time terms.
    rssgsp_div_pipe
    #(
        .NUM_W (QW),
        .DEN_W (DEN_W),
        .SB_W  (T12_W),
        .STEP  (DIV_STEP)
    ) u_div_ego
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .num       (fr_vr_sq),
        .den       (ego_den),
        .sb_in     (fr_t12),
        .out_valid (ego_valid),
        .quo       (ego_quo),
        .sb_out    (ego_t12)
    );

    // Lead braking distance; carries speed, gap and presence.
    rssgsp_div_pipe
    #(
        .NUM_W (QW),
        .DEN_W (DEN_W),
        .SB_W  (SB_W),
        .STEP  (DIV_STEP)
    ) u_div_lead
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .num       (fr_cm_sq),
        .den       (lead_den),
        .sb_in     ({fr_present, fr_gap, fr_speed}),
        .out_valid (lead_valid),
        .quo       (lead_quo),
        .sb_out    (lead_sb)
    );

    rssgsp_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ego_valid & lead_valid),
        .t12       (ego_t12),
        .t3        (ego_quo),
        .t4        (lead_quo),
        .speed     (lead_sb[OWN_SPEED_W-1:0]),
        .gap       (lead_sb[OWN_SPEED_W +: GAP_W]),
        .present   (lead_sb[SB_W-1]),
        .speed_cap (cfg.speed_cap),
        .en        (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign target_speed      = res.target_speed;
    assign collision_warning = res.collision_warning;
    assign emergency_brake   = res.emergency_brake;
    assign gap_zone          = res.gap_zone;
    assign safe_gap          = res.safe_gap;

endmodule

// ----- hdl/rssgsp_regs.sv -----
// ============================================================================
// rssgsp_regs: APB configuration registers
// Five planner registers at word addresses; writes keep the low bits of each
// register's width, writes beyond the map are dropped.
// ============================================================================
module rssgsp_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rssgsp_pkg::APB_AW-1:0] paddr,
    input  logic [rssgsp_pkg::APB_DW-1:0] pwdata,
    output logic [rssgsp_pkg::APB_DW-1:0] prdata,
    output logic                          pready,
    output rssgsp_pkg::cfg_t              cfg
);
    import rssgsp_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reaction_time  <= RST_REACTION_TIME;
            cfg_reg.max_accel      <= RST_MAX_ACCEL;
            cfg_reg.ego_min_brake  <= RST_EGO_MIN_BRAKE;
            cfg_reg.lead_max_brake <= RST_LEAD_MAX_BRAKE;
            cfg_reg.speed_cap      <= RST_SPEED_CAP;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_REACTION_TIME:  cfg_reg.reaction_time  <= pwdata[RHO_W-1:0];
                REG_MAX_ACCEL:      cfg_reg.max_accel      <= pwdata[ACC_W-1:0];
                REG_EGO_MIN_BRAKE:  cfg_reg.ego_min_brake  <= pwdata[BRK_W-1:0];
                REG_LEAD_MAX_BRAKE: cfg_reg.lead_max_brake <= pwdata[BRK_W-1:0];
                REG_SPEED_CAP:      cfg_reg.speed_cap      <= pwdata[CAP_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_REACTION_TIME:  prdata = APB_DW'(cfg_reg.reaction_time);
            REG_MAX_ACCEL:      prdata = APB_DW'(cfg_reg.max_accel);
            REG_EGO_MIN_BRAKE:  prdata = APB_DW'(cfg_reg.ego_min_brake);
            REG_LEAD_MAX_BRAKE: prdata = APB_DW'(cfg_reg.lead_max_brake);
            REG_SPEED_CAP:      prdata = APB_DW'(cfg_reg.speed_cap);
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- hdl/rssgsp_front.sv -----
// ============================================================================
// rssgsp_front: product stages of the safe-distance datapath
// Three register stages: reaction products, speed after reaction and lead
// speed square, ego speed square and the reaction-plus-acceleration sum.
// ============================================================================
module rssgsp_front
#(
    parameter int FRAC_BITS = rssgsp_pkg::FRAC_BITS_DEF
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic        [rssgsp_pkg::OWN_SPEED_W-1:0]     own_speed,
    input  logic signed [rssgsp_pkg::REL_SPEED_W-1:0]     lead_rel_speed,
    input  logic        [rssgsp_pkg::GAP_W-1:0]           lead_gap,
    input  logic                                          lead_present,
    input  rssgsp_pkg::cfg_t                              cfg,
    output logic                                          out_valid,
    output logic [rssgsp_pkg::quo_w(FRAC_BITS)-1:0]       vr_sq,
    output logic [rssgsp_pkg::quo_w(FRAC_BITS)-1:0]       cm_sq,
    output logic [rssgsp_pkg::t12_w(FRAC_BITS)-1:0]       t12,
    output logic [rssgsp_pkg::OWN_SPEED_W-1:0]            speed,
    output logic [rssgsp_pkg::GAP_W-1:0]                  gap,
    output logic                                          present
);
    import rssgsp_pkg::*;

    localparam int VR_W  = vr_w(FRAC_BITS);
    localparam int T1_W  = t1_w(FRAC_BITS);
    localparam int T2_W  = t2_w(FRAC_BITS);
    localparam int T12_W = t12_w(FRAC_BITS);
    localparam int QW    = quo_w(FRAC_BITS);
    localparam int RV_W  = RHO_W + OWN_SPEED_W;
    localparam int C_W   = OWN_SPEED_W + 2;

    // Stage 1
    logic                   s1_vld_reg;
    logic [RA_W-1:0]        s1_ra_reg;
    logic [T1_W-1:0]        s1_t1_reg;
    logic [CM_W-1:0]        s1_cm_reg;
    logic [OWN_SPEED_W-1:0] s1_v_reg;
    logic [GAP_W-1:0]       s1_gap_reg;
    logic                   s1_pres_reg;
    // Stage 2
    logic                   s2_vld_reg;
    logic [VR_W-1:0]        s2_vr_reg;
    logic [RAR_W-1:0]       s2_rar_reg;
    logic [QW-1:0]          s2_cm2_reg;
    logic [T1_W-1:0]        s2_t1_reg;
    logic [OWN_SPEED_W-1:0] s2_v_reg;
    logic [GAP_W-1:0]       s2_gap_reg;
    logic                   s2_pres_reg;
    // Stage 3
    logic                   s3_vld_reg;
    logic [QW-1:0]          s3_vr2_reg;
    logic [QW-1:0]          s3_cm2_reg;
    logic [T12_W-1:0]       s3_t12_reg;
    logic [OWN_SPEED_W-1:0] s3_v_reg;
    logic [GAP_W-1:0]       s3_gap_reg;
    logic                   s3_pres_reg;

    logic [RA_W-1:0]        ra_next;
    logic [RV_W-1:0]        rho_v;
    logic [T1_W-1:0]        t1_next;
    logic signed [C_W-1:0]  lead_abs_speed;
    logic [CM_W-1:0]        cm_next;
    logic [VR_W-1:0]        vr_next;
    logic [RAR_W-1:0]       rar_next;
    logic [2*CM_W-1:0]      cm2_full;
    logic [2*VR_W-1:0]      vr2_full;
    logic [T2_W-1:0]        t2_val;
    logic [T12_W-1:0]       t12_next;

    // Stage 1: rho*a, rho*v and |v + rel|
    assign ra_next        = RA_W'(cfg.reaction_time) * RA_W'(cfg.max_accel);
    assign rho_v          = RV_W'(cfg.reaction_time) * RV_W'(own_speed);
    assign t1_next        = T1_W'(rho_v >> FRAC_BITS);
    assign lead_abs_speed = $signed({2'b00, own_speed})
                          + $signed({{(C_W-REL_SPEED_W){lead_rel_speed[REL_SPEED_W-1]}},
                                     lead_rel_speed});
    assign cm_next        = lead_abs_speed[C_W-1] ? CM_W'(-lead_abs_speed)
                                                  : CM_W'(lead_abs_speed);

    // Stage 2: speed after reaction, rho*a*rho, lead speed square
    assign vr_next  = VR_W'(s1_v_reg) + VR_W'(s1_ra_reg >> FRAC_BITS);
    assign rar_next = RAR_W'(s1_ra_reg) * RAR_W'(cfg.reaction_time);
    assign cm2_full = (2*CM_W)'(s1_cm_reg) * (2*CM_W)'(s1_cm_reg);

    // Stage 3: ego speed square, reaction plus acceleration distance
    assign vr2_full = (2*VR_W)'(s2_vr_reg) * (2*VR_W)'(s2_vr_reg);
    assign t2_val   = T2_W'(s2_rar_reg >> (2 * FRAC_BITS + 1));
    assign t12_next = T12_W'(s2_t1_reg) + T12_W'(t2_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ra_reg   <= ra_next;
            s1_t1_reg   <= t1_next;
            s1_cm_reg   <= cm_next;
            s1_v_reg    <= own_speed;
            s1_gap_reg  <= lead_gap;
            s1_pres_reg <= lead_present;

            s2_vr_reg   <= vr_next;
            s2_rar_reg  <= rar_next;
            s2_cm2_reg  <= QW'(cm2_full);
            s2_t1_reg   <= s1_t1_reg;
            s2_v_reg    <= s1_v_reg;
            s2_gap_reg  <= s1_gap_reg;
            s2_pres_reg <= s1_pres_reg;

            s3_vr2_reg  <= QW'(vr2_full);
            s3_cm2_reg  <= s2_cm2_reg;
            s3_t12_reg  <= t12_next;
            s3_v_reg    <= s2_v_reg;
            s3_gap_reg  <= s2_gap_reg;
            s3_pres_reg <= s2_pres_reg;
        end
    end

    assign out_valid = s3_vld_reg;
    assign vr_sq     = s3_vr2_reg;
    assign cm_sq     = s3_cm2_reg;
    assign t12       = s3_t12_reg;
    assign speed     = s3_v_reg;
    assign gap       = s3_gap_reg;
    assign present   = s3_pres_reg;

endmodule

// ----- hdl/rssgsp_div_pipe.sv -----
// ============================================================================
// rssgsp_div_pipe: pipelined restoring divider
// Floor quotient of an unsigned dividend by an unsigned divisor, STEP
// quotient bits per register stage, with a sideband that travels alongside.
// ============================================================================
module rssgsp_div_pipe
#(
    parameter int NUM_W = 34,
    parameter int DEN_W = 13,
    parameter int SB_W  = 1,
    parameter int STEP  = rssgsp_pkg::DIV_STEP
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  sb_in,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo,
    output logic [SB_W-1:0]  sb_out
);
    import rssgsp_pkg::*;

    localparam int STAGES = (NUM_W + STEP - 1) / STEP;
    localparam int PAD_W  = STAGES * STEP;

    logic             vld_reg [STAGES];
    logic [DEN_W-1:0] rem_reg [STAGES];
    logic [PAD_W-1:0] num_reg [STAGES];
    logic [NUM_W-1:0] quo_reg [STAGES];
    logic [SB_W-1:0]  sb_reg  [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic             vld_in;
        logic [DEN_W-1:0] rem_in;
        logic [PAD_W-1:0] num_in;
        logic [NUM_W-1:0] quo_in;
        logic [SB_W-1:0]  sb_w;
        logic [DEN_W-1:0] rem_next;
        logic [PAD_W-1:0] num_next;
        logic [NUM_W-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign num_in = PAD_W'(num);
            assign quo_in = '0;
            assign sb_w   = sb_in;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign num_in = num_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign sb_w   = sb_reg[s-1];
        end

        // Shift in one dividend bit, subtract the divisor where it fits.
        always_comb
        begin
            logic [DEN_W:0]   r;
            logic [PAD_W-1:0] n;
            logic [NUM_W-1:0] q;
            r = {1'b0, rem_in};
            n = num_in;
            q = quo_in;
            for (int k = 0; k < STEP; k++)
            begin
                r = {r[DEN_W-1:0], n[PAD_W-1]};
                n = n << 1;
                q = q << 1;
                if (r >= {1'b0, den})
                begin
                    r    = r - {1'b0, den};
                    q[0] = 1'b1;
                end
            end
            rem_next = r[DEN_W-1:0];
            num_next = n;
            quo_next = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                num_reg[s] <= num_next;
                quo_reg[s] <= quo_next;
                sb_reg[s]  <= sb_w;
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign quo       = quo_reg[STAGES-1];
    assign sb_out    = sb_reg[STAGES-1];

endmodule

// ----- hdl/rssgsp_back.sv -----
// ============================================================================
// rssgsp_back: safe distance, zone choice, set speed and output buffer
// Four register stages after the divisions, then an output register with a
// skid entry; the skid entry holds the pipeline when the consumer stalls.
// ============================================================================
module rssgsp_back
#(
    parameter int FRAC_BITS = rssgsp_pkg::FRAC_BITS_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    input  logic [rssgsp_pkg::t12_w(FRAC_BITS)-1:0]  t12,
    input  logic [rssgsp_pkg::quo_w(FRAC_BITS)-1:0]  t3,
    input  logic [rssgsp_pkg::quo_w(FRAC_BITS)-1:0]  t4,
    input  logic [rssgsp_pkg::OWN_SPEED_W-1:0]       speed,
    input  logic [rssgsp_pkg::GAP_W-1:0]             gap,
    input  logic                                     present,
    input  logic [rssgsp_pkg::CAP_W-1:0]             speed_cap,
    output logic                                     en,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output rssgsp_pkg::res_t                         res
);
    import rssgsp_pkg::*;

    localparam int DR_W = dr_w(FRAC_BITS);
    localparam int TG_W = tg_w(FRAC_BITS);

    localparam logic signed [DR_W-1:0] D_FLOOR = DR_W'(5) << FRAC_BITS;
    localparam logic signed [DR_W-1:0] D_SAT   = DR_W'({SAFE_W{1'b1}});

    localparam logic signed [TG_W-1:0] DLT_ACCEL = TG_W'(64'sd1 << (FRAC_BITS - 1));
    localparam logic signed [TG_W-1:0] DLT_SOFT  = -DLT_ACCEL;
    localparam logic signed [TG_W-1:0] DLT_WARN  = -TG_W'(64'sd5 << (FRAC_BITS - 2));
    localparam logic signed [TG_W-1:0] DLT_EMERG = -TG_W'(64'sd5 << (FRAC_BITS - 1));

    // Stage A: raw safe distance
    logic                    sa_vld_reg;
    logic signed [DR_W-1:0]  sa_d_reg;
    logic [OWN_SPEED_W-1:0]  sa_v_reg;
    logic [GAP_W-1:0]        sa_gap_reg;
    logic                    sa_pres_reg;
    // Stage B: floored and saturated safe distance
    logic                    sb_vld_reg;
    logic [SAFE_W-1:0]       sb_d_reg;
    logic [OWN_SPEED_W-1:0]  sb_v_reg;
    logic [GAP_W-1:0]        sb_gap_reg;
    logic                    sb_pres_reg;
    // Stage C: zone
    logic                    sc_vld_reg;
    logic [SAFE_W-1:0]       sc_d_reg;
    logic [OWN_SPEED_W-1:0]  sc_v_reg;
    logic [ZONE_W-1:0]       sc_zone_reg;
    // Stage D: finished result
    logic                    sd_vld_reg;
    res_t                    sd_res_reg;
    // Output register and skid entry
    logic                    out_vld_reg;
    res_t                    out_res_reg;
    logic                    skid_vld_reg;
    res_t                    skid_res_reg;

    logic signed [DR_W-1:0]  d_raw_next;
    logic [SAFE_W-1:0]       d_next;
    logic [ZC_W-1:0]         g_x2;
    logic [ZC_W-1:0]         g_x4;
    logic [ZC_W-1:0]         g_x10;
    logic [ZC_W-1:0]         d_x1;
    logic [ZC_W-1:0]         d_x9;
    logic [ZC_W-1:0]         d_x11;
    logic [ZONE_W-1:0]       zone_next;
    logic signed [TG_W-1:0]  delta;
    logic signed [TG_W-1:0]  tgt_sum;
    logic signed [TG_W-1:0]  cap_s;
    logic [OWN_SPEED_W-1:0]  tgt_next;
    res_t                    res_next;
    logic                    transfer;

    // Stage A: t1 + t2 + t3 - t4
    assign d_raw_next = DR_W'(t12) + DR_W'(t3) - DR_W'(t4);

    // Stage B: floor at 5 m, saturate at the top of the field
    always_comb
    begin
        if (sa_d_reg < D_FLOOR)
            d_next = SAFE_W'(D_FLOOR);
        else if (sa_d_reg > D_SAT)
            d_next = SAFE_W'(D_SAT);
        else
            d_next = SAFE_W'(sa_d_reg);
    end

    // Stage C: gap ratio against 1.1, 0.9, 0.5 and 0.25 of the safe distance
    assign g_x2  = ZC_W'(sb_gap_reg) << 1;
    assign g_x4  = ZC_W'(sb_gap_reg) << 2;
    assign g_x10 = (ZC_W'(sb_gap_reg) << 3) + (ZC_W'(sb_gap_reg) << 1);
    assign d_x1  = ZC_W'(sb_d_reg);
    assign d_x9  = (d_x1 << 3) + d_x1;
    assign d_x11 = (d_x1 << 3) + (d_x1 << 1) + d_x1;

    always_comb
    begin
        if (!sb_pres_reg)
            zone_next = ZONE_ACCEL;
        else if (g_x10 >= d_x11)
            zone_next = ZONE_ACCEL;
        else if ((g_x2 >= d_x1) && (g_x10 <= d_x9))
            zone_next = ZONE_SOFT;
        else if ((g_x4 >= d_x1) && (g_x2 < d_x1))
            zone_next = ZONE_WARN;
        else if (g_x4 < d_x1)
            zone_next = ZONE_EMERG;
        else
            zone_next = ZONE_HOLD;
    end

    // Stage D: half the zone acceleration on top of ego speed, clamped
    always_comb
    begin
        case (sc_zone_reg)
            ZONE_ACCEL: delta = DLT_ACCEL;
            ZONE_SOFT:  delta = DLT_SOFT;
            ZONE_WARN:  delta = DLT_WARN;
            ZONE_EMERG: delta = DLT_EMERG;
            default:    delta = '0;
        endcase
    end

    assign tgt_sum = TG_W'(sc_v_reg) + delta;
    assign cap_s   = TG_W'(speed_cap);

    always_comb
    begin
        if (tgt_sum < 0)
            tgt_next = '0;
        else if (tgt_sum > cap_s)
            tgt_next = speed_cap;
        else
            tgt_next = OWN_SPEED_W'(tgt_sum);
    end

    always_comb
    begin
        res_next.target_speed      = tgt_next;
        res_next.collision_warning = (sc_zone_reg == ZONE_WARN) || (sc_zone_reg == ZONE_EMERG);
        res_next.emergency_brake   = (sc_zone_reg == ZONE_EMERG);
        res_next.gap_zone          = sc_zone_reg;
        res_next.safe_gap          = sc_d_reg;
    end

    // Freeze every stage while the skid entry is occupied.
    assign en       = ~skid_vld_reg;
    assign transfer = en & sd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_vld_reg <= 1'b0;
            sb_vld_reg <= 1'b0;
            sc_vld_reg <= 1'b0;
            sd_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sa_vld_reg <= in_valid;
            sb_vld_reg <= sa_vld_reg;
            sc_vld_reg <= sb_vld_reg;
            sd_vld_reg <= sc_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_d_reg    <= d_raw_next;
            sa_v_reg    <= speed;
            sa_gap_reg  <= gap;
            sa_pres_reg <= present;

            sb_d_reg    <= d_next;
            sb_v_reg    <= sa_v_reg;
            sb_gap_reg  <= sa_gap_reg;
            sb_pres_reg <= sa_pres_reg;

            sc_d_reg    <= sb_pres_reg ? sb_d_reg : '0;
            sc_v_reg    <= sb_v_reg;
            sc_zone_reg <= zone_next;

            sd_res_reg  <= res_next;
        end
    end

    // Output register plus one skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (out_ready)
                skid_vld_reg <= 1'b0;
        end
        else if (transfer)
        begin
            if (out_vld_reg && !out_ready)
                skid_vld_reg <= 1'b1;
            else
                out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_ready)
                out_res_reg <= skid_res_reg;
        end
        else if (transfer)
        begin
            if (out_vld_reg && !out_ready)
                skid_res_reg <= sd_res_reg;
            else
                out_res_reg <= sd_res_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign res       = out_res_reg;

endmodule
